// ===== src/tlts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the two-level thread scheduler.
// No dependencies; every other file of the block imports this package.
package tlts_pkg;

  // Number of thread slots and the widths that follow from it.
  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // Fixed field widths of the channels.
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 4;
  localparam int QT_W     = 8;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [QT_W-1:0]  quantum_t;

  localparam id_t                    LAST_ID       = ID_W'(MAX_THREADS - 1);
  localparam logic [MAX_THREADS-1:0] USED_RESET    = MAX_THREADS'(1);
  localparam quantum_t               QUANTUM_RESET = QT_W'(10);

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 2'd0,
    MODE_CREATE   = 2'd1,
    MODE_EXIT     = 2'd2,
    MODE_SET_PRIO = 2'd3
  } mode_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_NO_SWITCH = 3'd0,
    STAT_SWITCHED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FINISHED  = 3'd3,
    STAT_HALTED    = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Controller to queue: one push and one pop per update.
  typedef struct packed {
    logic push;
    logic pop;
    id_t  push_id;
  } queue_ctrl_t;

  // Queue to controller: emptiness and the registered head entry.
  typedef struct packed {
    logic empty;
    id_t  head_id;
  } queue_stat_t;

  // Widen or cut a slot id to the fixed id field of the response.
  function automatic logic [FIELD_W-1:0] to_field(input id_t id);
    logic [ID_W+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, id};
    return wide[FIELD_W-1:0];
  endfunction

endpackage

// ===== src/tlts_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the thread scheduler: request, response and quantum write.
// Depends on tlts_pkg for the field widths.

// Request channel: one scheduling event per request.
interface tlts_cmd_if import tlts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              priority_req;

  modport source (output valid, output mode, output priority_req, input ready);
  modport sink (input valid, input mode, input priority_req, output ready);
endinterface

// Response channel: one result per request.
interface tlts_rsp_if import tlts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  running_id;
  logic [FIELD_W-1:0]  previous_id;
  logic [FIELD_W-1:0]  created_id;
  logic                running_priority;

  modport source (output valid, output status, output running_id, output previous_id,
                  output created_id, output running_priority, input ready);
  modport sink (input valid, input status, input running_id, input previous_id,
                input created_id, input running_priority, output ready);
endinterface

// Quantum register write channel.
interface tlts_cfg_if import tlts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [QT_W-1:0] quantum_len;

  modport source (output valid, output quantum_len, input ready);
  modport sink (input valid, input quantum_len, output ready);
endinterface

// ===== src/tlts_queue.sv =====
`timescale 1ns / 1ps
// Circular queue of slot ids held in a synchronous memory, with head, tail and count.
// Depends on tlts_pkg for the id width, depth and control structs.
module tlts_queue
  import tlts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_ctrl_t ctrl,
  output queue_stat_t stat
);

  id_t  mem [MAX_THREADS];
  id_t  head;
  id_t  tail;
  cnt_t count;
  id_t  head_data;
  logic push_ok;

  // A push into a full queue is dropped unless a pop frees an entry first.
  assign push_ok = ctrl.push && ((count != CNT_W'(MAX_THREADS)) || ctrl.pop);

  // Memory write at the tail and registered read of the head.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= ctrl.push_id;
    end
    head_data <= mem[head];
  end

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= (head == LAST_ID) ? '0 : head + 1'b1;
      end
      if (push_ok) begin
        tail <= (tail == LAST_ID) ? '0 : tail + 1'b1;
      end
      count <= count + CNT_W'(push_ok) - CNT_W'(ctrl.pop);
    end
  end

  assign stat.empty   = (count == '0);
  assign stat.head_id = head_data;

endmodule

// ===== src/two_level_thread_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the two-level thread scheduler.
// Depends on tlts_pkg, the channel interfaces and tlts_queue.
//
// Usage: every request on cmd carries one event (tick, create, exit of the
// running thread, or set priority of the running thread) and yields exactly one
// response on rsp with the status, the running slot after the event, the slot
// running before it, the created slot and the running priority.
// High priority threads wait in a FIFO queue; a newly created one preempts a
// running low one. Low threads rotate round robin when their quantum of ticks
// runs out. cfg, always ready, writes the quantum register (reset value 10);
// the user must write it only while no request is in flight, which the block
// itself does not enforce. An accepted request is held in req_mode and req_prio
// until it commits to the scheduler and response registers, once the response
// register is free. A new request is taken only after the previous one has
// committed, from the idle state, since the queue heads come from a registered
// memory read that must see the write of the previous update.
// Reset (synchronous, active high) empties both queues, frees every slot but
// slot 0, which runs at low priority, and leaves no response pending.
// If rsp stalls, one further request is accepted and held until the response
// register drains; the update is made only then.
module two_level_thread_scheduler
  import tlts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  tlts_cmd_if.sink  cmd,
  tlts_rsp_if.source rsp,
  tlts_cfg_if.sink  cfg
);

  // Controller state.
  state_e                 state;
  state_e                 state_next;
  mode_e                  req_mode;
  logic                   req_prio;
  logic                   accept;
  logic                   commit;

  // Scheduler registers.
  quantum_t               quantum;
  logic [MAX_THREADS-1:0] slot_used;
  logic [MAX_THREADS-1:0] slot_prio;
  id_t                    current;
  quantum_t               ticks_left;
  logic                   halted;

  // Update results.
  logic [MAX_THREADS-1:0] slot_used_next;
  logic [MAX_THREADS-1:0] slot_prio_next;
  id_t                    current_next;
  quantum_t               ticks_left_next;
  logic                   halted_next;
  status_e                status_next;
  id_t                    created_next;

  // Response register.
  logic                   out_valid;
  status_e                out_status;
  id_t                    out_running;
  id_t                    out_previous;
  id_t                    out_created;
  logic                   out_prio;

  // Queue interfaces and helpers.
  queue_ctrl_t            hi_ctrl;
  queue_ctrl_t            lo_ctrl;
  queue_stat_t            hi_stat;
  queue_stat_t            lo_stat;
  logic                   free_found;
  id_t                    free_id;
  quantum_t               ticks_dec;
  logic                   do_switch;
  id_t                    switch_id;
  logic                   take_head;
  id_t                    pick_id;

  tlts_queue u_high_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (hi_ctrl),
    .stat (hi_stat)
  );

  tlts_queue u_low_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lo_ctrl),
    .stat (lo_stat)
  );

  // Handshakes.
  assign accept    = cmd.valid && cmd.ready;
  assign commit    = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    cmd.ready = 1'b0;
    case (state)
      S_IDLE:  cmd.ready = 1'b1;
      S_EXEC:  cmd.ready = 1'b0;
      default: cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode_e'(cmd.mode);
      req_prio <= cmd.priority_req;
    end
  end

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_id    = ID_W'(i);
      end
    end
  end

  assign ticks_dec = (ticks_left != '0) ? ticks_left - 1'b1 : '0;
  assign pick_id   = hi_stat.empty ? lo_stat.head_id : hi_stat.head_id;

  // Event decode: what the update does to slots, queues and the running thread.
  always_comb begin
    slot_used_next  = slot_used;
    slot_prio_next  = slot_prio;
    current_next    = current;
    ticks_left_next = ticks_left;
    halted_next     = halted;
    status_next     = STAT_NO_SWITCH;
    created_next    = '0;
    do_switch       = 1'b0;
    switch_id       = '0;
    take_head       = 1'b0;
    hi_ctrl         = '0;
    lo_ctrl         = '0;
    if (halted) begin
      status_next = STAT_HALTED;
    end else begin
      case (req_mode)
        MODE_TICK: begin
          ticks_left_next = ticks_dec;
          if ((ticks_dec == '0) && !slot_prio[current]) begin
            if (hi_stat.empty && lo_stat.empty) begin
              ticks_left_next = quantum;
            end else begin
              do_switch = 1'b1;
              take_head = 1'b1;
              switch_id = pick_id;
            end
          end
        end
        MODE_CREATE: begin
          if (!free_found) begin
            status_next = STAT_FULL;
          end else begin
            slot_used_next[free_id] = 1'b1;
            slot_prio_next[free_id] = req_prio;
            created_next            = free_id;
            if (!req_prio) begin
              lo_ctrl.push    = 1'b1;
              lo_ctrl.push_id = free_id;
            end else if (!slot_prio[current]) begin
              do_switch = 1'b1;
              switch_id = free_id;
            end else begin
              hi_ctrl.push    = 1'b1;
              hi_ctrl.push_id = free_id;
            end
          end
        end
        MODE_EXIT: begin
          slot_used_next[current] = 1'b0;
          if (hi_stat.empty && lo_stat.empty) begin
            halted_next = 1'b1;
            status_next = STAT_FINISHED;
          end else begin
            do_switch = 1'b1;
            take_head = 1'b1;
            switch_id = pick_id;
          end
        end
        MODE_SET_PRIO: begin
          slot_prio_next[current] = req_prio;
        end
        default: begin
          status_next = STAT_NO_SWITCH;
        end
      endcase
    end

    // Pop the chosen head and move a still-live running thread to the low queue.
    if (take_head) begin
      hi_ctrl.pop = !hi_stat.empty;
      lo_ctrl.pop = hi_stat.empty;
    end
    if (do_switch) begin
      status_next     = STAT_SWITCHED;
      current_next    = switch_id;
      ticks_left_next = quantum;
      if (slot_used_next[current]) begin
        lo_ctrl.push    = 1'b1;
        lo_ctrl.push_id = current;
      end
    end

    // Queues change only on the committing cycle.
    if (!commit) begin
      hi_ctrl = '0;
      lo_ctrl = '0;
    end
  end

  // Quantum register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      quantum <= cfg.quantum_len;
    end
  end

  // Scheduler state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= USED_RESET;
      slot_prio  <= '0;
      current    <= '0;
      ticks_left <= QUANTUM_RESET;
      halted     <= 1'b0;
    end else if (commit) begin
      slot_used  <= slot_used_next;
      slot_prio  <= slot_prio_next;
      current    <= current_next;
      ticks_left <= ticks_left_next;
      halted     <= halted_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status   <= status_next;
      out_running  <= current_next;
      out_previous <= current;
      out_created  <= created_next;
      out_prio     <= slot_prio_next[current_next];
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.running_id       = to_field(out_running);
  assign rsp.previous_id      = to_field(out_previous);
  assign rsp.created_id       = to_field(out_created);
  assign rsp.running_priority = out_prio;

endmodule

// ===== src/tlts_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the thread scheduler, bound to the top level.
// Depends on tlts_pkg for the status codes and field widths.
module tlts_checker
  import tlts_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [FIELD_W-1:0]  rsp_running_id,
  input logic [FIELD_W-1:0]  rsp_previous_id
);

  // Reset leaves no response pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Requests are taken one at a time: a request is never accepted back to back.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("request accepted in consecutive cycles");

  // A switch always lands on another slot.
  a_switch_moves: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == STAT_SWITCHED)) |-> (rsp_running_id != rsp_previous_id))
    else $error("switch reported to the same slot");

  // Without a switch the running slot is unchanged.
  a_no_switch_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != STAT_SWITCHED)) |-> (rsp_running_id == rsp_previous_id))
    else $error("running slot changed without a switch");

endmodule

bind two_level_thread_scheduler tlts_checker u_tlts_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_status      (rsp.status),
  .rsp_running_id  (rsp.running_id),
  .rsp_previous_id (rsp.previous_id)
);
